// ===== rtl/rdlm_pkg.sv =====
`default_nettype none

package rdlm_pkg;

   // Fixed geometry of the meter
   localparam int MAX_CHANNELS  = 8;
   localparam int SAMPLE_BITS   = 24;
   localparam int METER_CELLS   = 40;

   // Field and register widths
   localparam int CHCFG_W   = 4;
   localparam int WIN_W     = 14;
   localparam int CH_IDX_W  = $clog2(MAX_CHANNELS);
   localparam int FSUM_W    = SAMPLE_BITS + $clog2(MAX_CHANNELS);
   localparam int SQSUM_W   = 61;
   localparam int RMS_W     = 24;
   localparam int DB_W      = 12;
   localparam int CELLS_W   = 6;

   // CSR port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_FRAMES = 2'd1;
   localparam logic [CHCFG_W-1:0]   CHANNEL_COUNT_RST = 4'd2;
   localparam logic [WIN_W-1:0]     WINDOW_FRAMES_RST = 14'd2400;

   // Shared divider: 61-bit dividend, 14-bit divisor, one quotient bit a step
   localparam int DIV_W      = 61;
   localparam int DVSR_W     = 14;
   localparam int DIV_STEPS  = DIV_W;

   // Square root: one result bit a step over a 61-bit radicand
   localparam int SQRT_STEPS = 31;

   // Log2 by repeated squaring
   localparam int X_W           = 32;
   localparam int PROD_W        = 64;
   localparam int LOG_FRAC_BITS = 16;
   localparam int LOG_E_W       = 5;
   localparam int L2_W          = LOG_E_W + LOG_FRAC_BITS;
   localparam logic [L2_W-1:0]  FULL_L2 = L2_W'((SAMPLE_BITS - 1) << LOG_FRAC_BITS);
   localparam logic [21:0]      DB_K_Q16 = 22'd3945660;
   localparam logic signed [DB_W-1:0] ZERO_TENTHS = -12'sd1200;
   localparam int CELL_SPAN = 600;
   // n * 40 / 600 is n / 15; ceil(2^16 / 15) is exact for n up to 600
   localparam logic [12:0]      CELL_RECIP_Q16 = 13'd4370;

   // Step counter
   localparam int CNT_W = 6;

   // Datapath commands
   typedef struct packed {
      logic take_sample;
      logic frame_load;
      logic div_step;
      logic sq_mul;
      logic acc_update;
      logic mean_load;
      logic sqrt_load;
      logic sqrt_step;
      logic x_load;
      logic norm_step;
      logic zero_level;
      logic log_mul;
      logic log_shift;
      logic db_mul;
      logic db_fin;
      logic cell_load;
      logic out_write;
   } dp_cmd_type;

   // Datapath status
   typedef struct packed {
      logic frame_end;
      logic window_done;
      logic rms_zero;
      logic x_msb;
      logic cell_pos;
      logic out_busy;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== rtl/rdlm_dp.sv =====
`default_nettype none

module rdlm_dp
   import rdlm_pkg::*;
(
   input  wire                          clock,
   input  wire                          reset,
   input  dp_cmd_type                   cmd,
   output dp_sts_type                   sts,
   input  wire  signed [SAMPLE_BITS-1:0] req_sample,
   input  wire                          csr_valid,
   input  wire         [CSR_IDX_W-1:0]  csr_index,
   input  wire         [CSR_DATA_W-1:0] csr_wdata,
   input  wire                          rsp_ready,
   output logic                         rsp_valid,
   output logic        [RMS_W-1:0]      rsp_level_rms,
   output logic signed [DB_W-1:0]       rsp_level_db_tenths,
   output logic        [CELLS_W-1:0]    rsp_meter_cells
);

   // Configuration
   logic [CHCFG_W-1:0] chan_cfg_ff;
   logic [WIN_W-1:0]   win_cfg_ff;
   logic [CHCFG_W-1:0] chans_eff;
   logic [WIN_W-1:0]   win_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cfg_ff <= CHANNEL_COUNT_RST;
         win_cfg_ff  <= WINDOW_FRAMES_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANNEL_COUNT: chan_cfg_ff <= csr_wdata[CHCFG_W-1:0];
            CSR_WINDOW_FRAMES: win_cfg_ff  <= csr_wdata[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (chan_cfg_ff == '0)
         chans_eff = CHCFG_W'(1);
      else if (chan_cfg_ff > CHCFG_W'(MAX_CHANNELS))
         chans_eff = CHCFG_W'(MAX_CHANNELS);
      else
         chans_eff = chan_cfg_ff;
      win_eff = (win_cfg_ff == '0) ? WIN_W'(1) : win_cfg_ff;
   end

   // Accumulators
   logic signed [FSUM_W-1:0] fsum_ff;
   logic [CH_IDX_W-1:0]      ch_idx_ff;
   logic [SQSUM_W-1:0]       sqsum_ff;
   logic [WIN_W-1:0]         fcnt_ff;
   logic [WIN_W-1:0]         fcnt_in;
   logic [FSUM_W-1:0]        fsum_mag;

   // Divider, square root, log and product registers
   logic [DIV_W-1:0]      quo_ff;
   logic [DVSR_W:0]       rem_ff;
   logic [DVSR_W-1:0]     dvsr_ff;
   logic [DVSR_W:0]       div_t;
   logic                  div_ge;
   logic [SQSUM_W-1:0]    sq_v_ff;
   logic [SQSUM_W-1:0]    sq_res_ff;
   logic [SQSUM_W-1:0]    sq_bit_ff;
   logic [SQSUM_W-1:0]    sq_try;
   logic [RMS_W-1:0]      rms_ff;
   logic [X_W-1:0]        x_ff;
   logic [LOG_E_W-1:0]    e_ff;
   logic [LOG_FRAC_BITS-1:0] frac_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [X_W-1:0]        mul_a;
   logic [X_W-1:0]        mul_b;
   logic [X_W:0]          sq_shr;
   logic [L2_W-1:0]       l2;
   logic [L2_W-1:0]       m_val;
   logic [43:0]           db_round;
   logic signed [DB_W-1:0] tenths_ff;
   logic signed [DB_W:0]   n_val;
   logic [22:0]           cell_prod;
   logic [CELLS_W-1:0]    cell_q;
   logic [CELLS_W-1:0]    cells_ff;

   always_comb begin
      fcnt_in = fcnt_ff + WIN_W'(1);
      if (fcnt_in == '0)
         fcnt_in = WIN_W'(1);
      fsum_mag = fsum_ff[FSUM_W-1] ? FSUM_W'(-fsum_ff) : FSUM_W'(fsum_ff);
      div_t    = {rem_ff[DVSR_W-1:0], quo_ff[DIV_W-1]};
      div_ge   = div_t >= {1'b0, dvsr_ff};
      sq_try   = sq_res_ff + sq_bit_ff;
      sq_shr   = prod_ff[X_W+31:31];
      l2       = {e_ff, frac_ff};
      m_val    = (l2 >= FULL_L2) ? '0 : FULL_L2 - l2;
      db_round = prod_ff[43:0] + 44'(64'd1 << 31);
      n_val    = $signed({tenths_ff[DB_W-1], tenths_ff}) + (DB_W+1)'(CELL_SPAN);
      // n is at most 600 here, so ten bits carry it
      cell_prod = n_val[9:0] * CELL_RECIP_Q16;
      cell_q    = cell_prod[21:16];
   end

   // Shared multiplier operand select
   always_comb begin
      mul_a = x_ff;
      mul_b = x_ff;
      if (cmd.sq_mul) begin
         mul_a = X_W'(quo_ff[RMS_W-1:0]);
         mul_b = X_W'(quo_ff[RMS_W-1:0]);
      end else if (cmd.db_mul) begin
         mul_a = X_W'(m_val);
         mul_b = X_W'(DB_K_Q16);
      end
   end

   // Frame and window accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         fsum_ff   <= '0;
         ch_idx_ff <= '0;
         sqsum_ff  <= '0;
         fcnt_ff   <= '0;
      end else begin
         if (cmd.take_sample) begin
            fsum_ff   <= fsum_ff + FSUM_W'(req_sample);
            ch_idx_ff <= sts.frame_end ? '0 : ch_idx_ff + CH_IDX_W'(1);
         end
         if (cmd.frame_load)
            fsum_ff <= '0;
         if (cmd.acc_update) begin
            sqsum_ff <= sqsum_ff + prod_ff[SQSUM_W-1:0];
            fcnt_ff  <= fcnt_in;
         end
         if (cmd.mean_load) begin
            sqsum_ff <= '0;
            fcnt_ff  <= '0;
         end
      end
   end

   // Arithmetic units
   always_ff @(posedge clock) begin
      if (cmd.frame_load) begin
         quo_ff  <= DIV_W'(fsum_mag);
         rem_ff  <= '0;
         dvsr_ff <= DVSR_W'(chans_eff);
      end else if (cmd.mean_load) begin
         quo_ff  <= sqsum_ff;
         rem_ff  <= '0;
         dvsr_ff <= fcnt_ff;
      end else if (cmd.div_step) begin
         rem_ff <= div_ge ? div_t - {1'b0, dvsr_ff} : div_t;
         quo_ff <= {quo_ff[DIV_W-2:0], div_ge};
      end

      if (cmd.sq_mul || cmd.log_mul || cmd.db_mul)
         prod_ff <= mul_a * mul_b;

      // bit-pair square root
      if (cmd.sqrt_load) begin
         sq_v_ff   <= quo_ff;
         sq_res_ff <= '0;
         sq_bit_ff <= SQSUM_W'(1) << (SQSUM_W - 1);
      end else if (cmd.sqrt_step) begin
         if (sq_v_ff >= sq_try) begin
            sq_v_ff   <= sq_v_ff - sq_try;
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
         sq_bit_ff <= sq_bit_ff >> 2;
      end

      // log2 mantissa and exponent
      if (cmd.x_load) begin
         rms_ff  <= sq_res_ff[RMS_W-1:0];
         x_ff    <= {sq_res_ff[RMS_W-1:0], (X_W-RMS_W)'(0)};
         e_ff    <= LOG_E_W'(SAMPLE_BITS - 1);
         frac_ff <= '0;
      end else if (cmd.norm_step) begin
         x_ff <= x_ff << 1;
         e_ff <= e_ff - LOG_E_W'(1);
      end else if (cmd.log_shift) begin
         frac_ff <= {frac_ff[LOG_FRAC_BITS-2:0], sq_shr[X_W]};
         x_ff    <= sq_shr[X_W] ? sq_shr[X_W:1] : sq_shr[X_W-1:0];
      end

      // level and meter
      if (cmd.zero_level) begin
         tenths_ff <= ZERO_TENTHS;
         cells_ff  <= '0;
      end else if (cmd.db_fin) begin
         tenths_ff <= -$signed(db_round[43:32]);
      end
      if (cmd.cell_load) begin
         if (!sts.cell_pos)
            cells_ff <= '0;
         else if (cell_q > CELLS_W'(METER_CELLS))
            cells_ff <= CELLS_W'(METER_CELLS);
         else
            cells_ff <= cell_q;
      end
   end

   // Result word register
   logic                   rsp_valid_ff;
   logic [RMS_W-1:0]       rsp_rms_ff;
   logic signed [DB_W-1:0] rsp_db_ff;
   logic [CELLS_W-1:0]     rsp_cells_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_write) begin
         rsp_rms_ff   <= rms_ff;
         rsp_db_ff    <= tenths_ff;
         rsp_cells_ff <= cells_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_level_rms       = rsp_rms_ff;
   assign rsp_level_db_tenths = rsp_db_ff;
   assign rsp_meter_cells     = rsp_cells_ff;

   // Status to controller
   always_comb begin
      sts.frame_end   = (CHCFG_W'(ch_idx_ff) + CHCFG_W'(1)) >= chans_eff;
      sts.window_done = fcnt_in >= win_eff;
      sts.rms_zero    = (rms_ff == '0);
      sts.x_msb       = x_ff[X_W-1];
      sts.cell_pos    = (n_val > 0);
      sts.out_busy    = rsp_valid_ff;
   end

   // Checks
   a_out_write_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |=> rsp_valid_ff)
      else $error("result word not presented after write");

   a_cells_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_cells_ff <= CELLS_W'(METER_CELLS)))
      else $error("meter cell count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_write |-> !rsp_valid_ff)
      else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/rdlm_ctrl.sv =====
`default_nettype none

module rdlm_ctrl
   import rdlm_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_FLOAD  = 5'd1;
   localparam logic [4:0] S_FDIV   = 5'd2;
   localparam logic [4:0] S_SQ     = 5'd3;
   localparam logic [4:0] S_ACC    = 5'd4;
   localparam logic [4:0] S_MLOAD  = 5'd5;
   localparam logic [4:0] S_MDIV   = 5'd6;
   localparam logic [4:0] S_SQLOAD = 5'd7;
   localparam logic [4:0] S_SQRT   = 5'd8;
   localparam logic [4:0] S_XLOAD  = 5'd9;
   localparam logic [4:0] S_NORM   = 5'd10;
   localparam logic [4:0] S_LOGM   = 5'd11;
   localparam logic [4:0] S_LOGS   = 5'd12;
   localparam logic [4:0] S_DBM    = 5'd13;
   localparam logic [4:0] S_DBF    = 5'd14;
   localparam logic [4:0] S_CLOAD  = 5'd15;
   localparam logic [4:0] S_OUT    = 5'd16;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_sample = 1'b1;
               if (sts.frame_end)
                  state_in = S_FLOAD;
            end
         end
         S_FLOAD: begin
            cmd.frame_load = 1'b1;
            cnt_in   = '0;
            state_in = S_FDIV;
         end
         S_FDIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1))
               state_in = S_SQ;
         end
         S_SQ: begin
            cmd.sq_mul = 1'b1;
            state_in   = S_ACC;
         end
         S_ACC: begin
            cmd.acc_update = 1'b1;
            state_in = sts.window_done ? S_MLOAD : S_IDLE;
         end
         S_MLOAD: begin
            cmd.mean_load = 1'b1;
            cnt_in   = '0;
            state_in = S_MDIV;
         end
         S_MDIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_STEPS - 1))
               state_in = S_SQLOAD;
         end
         S_SQLOAD: begin
            cmd.sqrt_load = 1'b1;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1))
               state_in = S_XLOAD;
         end
         S_XLOAD: begin
            cmd.x_load = 1'b1;
            state_in   = S_NORM;
         end
         S_NORM: begin
            if (sts.rms_zero) begin
               cmd.zero_level = 1'b1;
               state_in = S_OUT;
            end else if (sts.x_msb) begin
               cnt_in   = '0;
               state_in = S_LOGM;
            end else begin
               cmd.norm_step = 1'b1;
            end
         end
         S_LOGM: begin
            cmd.log_mul = 1'b1;
            state_in    = S_LOGS;
         end
         S_LOGS: begin
            cmd.log_shift = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            state_in = (cnt_ff == CNT_W'(LOG_FRAC_BITS - 1)) ? S_DBM : S_LOGM;
         end
         S_DBM: begin
            cmd.db_mul = 1'b1;
            state_in   = S_DBF;
         end
         S_DBF: begin
            cmd.db_fin = 1'b1;
            state_in   = S_CLOAD;
         end
         S_CLOAD: begin
            cmd.cell_load = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!sts.out_busy) begin
               cmd.out_write = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rms_dbfs_level_meter_core.sv =====
`default_nettype none

// RMS level meter in dBFS. Interleaved Q1.23 samples enter one word at a time;
// each frame of channel_count samples is averaged to mono, squared and summed,
// and after window_frames frames one word comes out with the floor RMS, the
// level in tenths of dBFS (-1200 for silence) and a 0..40 meter cell count.
// A sample that does not end a frame is only added to the frame sum. A frame
// end runs the 61-step shared divider that forms the mono value; no sample is
// taken meanwhile. A window end adds a 61-step mean divide, a 31-step square
// root, up to 23 normalize shifts, 16 log2 squarings on the shared multiplier,
// each a multiply and a shift, and a reciprocal multiply for the meter cells.
// A finished result waits in its own output register while new samples are
// taken; a second result stalls the input until the first one is taken.
module rms_dbfs_level_meter_core
   import rdlm_pkg::*;
(
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire  signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic        [RMS_W-1:0]       rsp_level_rms,
   output logic signed [DB_W-1:0]        rsp_level_db_tenths,
   output logic        [CELLS_W-1:0]     rsp_meter_cells,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire         [CSR_IDX_W-1:0]   csr_index,
   input  wire         [CSR_DATA_W-1:0]  csr_wdata
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Register writes always land at once
   assign csr_ready = 1'b1;

   rdlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rdlm_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_sample          (req_sample),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_level_rms       (rsp_level_rms),
      .rsp_level_db_tenths (rsp_level_db_tenths),
      .rsp_meter_cells     (rsp_meter_cells)
   );

endmodule

`default_nettype wire
